@@ rtl/sbe_pkg.sv @@
package sbe_pkg;

  localparam int GROUP_BITS = 7;
  localparam int MAX_GROUPS = 10;
  localparam int VALUE_BITS = 64;
  localparam int EXT_BITS = GROUP_BITS * MAX_GROUPS;
  localparam int GRP_W = $clog2(MAX_GROUPS + 1);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] STOP_MASK = 8'h80;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value_bits;
    logic                  is_signed;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value_bits;
    logic                  is_signed;
    logic [GRP_W-1:0]      groups;
  } entry_t;

endpackage

@@ rtl/stop_bit_integer_encoder_top.sv @@
// stop-bit integer encoder
// an item (64-bit value plus signed flag) is taken at a rising edge with
// start high and busy low. the block emits the shortest big-endian run of
// 7-bit groups, one to ten bytes, most significant group first, each byte on
// result for one cycle with strobe high; the final byte has bit 7 set and
// last_byte high.
// an item that is taken is first written into the queue and then loaded into
// the serialiser, which sends its first byte once it is free.
// throughput: one byte per cycle, set by the byte serialiser. the bytes of
// successive items follow one another with no gap when the next item is
// already waiting in the queue.
// a small queue between the classifier and the serialiser takes new requests
// while earlier ones are still being sent; busy is high while it is full.
// the receiver cannot stall: every strobe cycle is a delivered byte.
// reset (synchronous) empties the queue and stops any output in progress.
module stop_bit_integer_encoder_top #(
  parameter int QUEUE_DEPTH = sbe_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  sbe_pkg::in_t  item,
  output logic          strobe,
  output sbe_pkg::out_t result
);

  sbe_pkg::entry_t front_entry;
  sbe_pkg::entry_t head;
  logic            empty;
  logic            full;
  logic            pop;
  logic            push;

  assign busy = full;
  assign push = start && !full;

  sbe_front u_front (
    .item  (item),
    .entry (front_entry)
  );

  sbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_entry),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  sbe_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .strobe (strobe),
    .result (result)
  );

  a_stop_bit: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (result.out_byte[7] == result.last_byte))
    else $error("stop bit does not match last byte");

  a_unbroken_run: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_byte |=> strobe)
    else $error("byte run broken before last byte");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !strobe && !busy)
    else $error("output or busy after reset");

endmodule

@@ rtl/sbe_front.sv @@
module sbe_front (
  input  sbe_pkg::in_t    item,
  output sbe_pkg::entry_t entry
);

  logic [sbe_pkg::GRP_W-1:0] groups;

  // fewest groups that hold the value, ten when none of the shorter forms fit
  always_comb begin
    logic [sbe_pkg::VALUE_BITS-1:0] v;
    logic                           fits;
    v = item.value_bits;
    groups = sbe_pkg::GRP_W'(sbe_pkg::MAX_GROUPS);
    for (int n = sbe_pkg::MAX_GROUPS - 1; n >= 1; n--) begin
      if (item.is_signed) begin
        fits = ((v >> (sbe_pkg::GROUP_BITS * n - 1)) == '0) ||
               ((~v >> (sbe_pkg::GROUP_BITS * n - 1)) == '0);
      end else begin
        fits = (v >> (sbe_pkg::GROUP_BITS * n)) == '0;
      end
      if (fits) begin
        groups = sbe_pkg::GRP_W'(n);
      end
    end
  end

  assign entry.value_bits = item.value_bits;
  assign entry.is_signed  = item.is_signed;
  assign entry.groups     = groups;

endmodule

@@ rtl/sbe_queue.sv @@
module sbe_queue #(
  parameter int DEPTH = sbe_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sbe_pkg::entry_t push_data,
  input  logic            pop,
  output sbe_pkg::entry_t head,
  output logic            empty,
  output logic            full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sbe_pkg::entry_t   mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/sbe_back.sv @@
module sbe_back (
  input  logic            clk,
  input  logic            rst,
  input  sbe_pkg::entry_t head,
  input  logic            empty,
  output logic            pop,
  output logic            strobe,
  output sbe_pkg::out_t   result
);

  logic                            active;
  logic [sbe_pkg::GRP_W-1:0]       grp;
  logic [sbe_pkg::EXT_BITS-1:0]    data;
  logic                            final_grp;

  assign final_grp = (grp == '0);
  assign pop       = !empty && (!active || final_grp);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      grp    <= '0;
    end else if (pop) begin
      active <= 1'b1;
      grp    <= head.groups - 1'b1;
    end else if (active) begin
      if (final_grp) begin
        active <= 1'b0;
      end else begin
        grp <= grp - 1'b1;
      end
    end
  end

  // top group padded with zeros or copies of the sign bit
  always_ff @(posedge clk) begin
    if (pop) begin
      data <= {{(sbe_pkg::EXT_BITS - sbe_pkg::VALUE_BITS)
                {head.is_signed & head.value_bits[sbe_pkg::VALUE_BITS-1]}},
               head.value_bits};
    end
  end

  assign strobe = active;
  assign result.out_byte = {1'b0, data[sbe_pkg::GROUP_BITS * grp +: sbe_pkg::GROUP_BITS]} |
                           (final_grp ? sbe_pkg::STOP_MASK : 8'h00);
  assign result.last_byte = final_grp;

endmodule
